[hw/rtl/dlmc_pkg.sv]
// Desk lift motion controller package: codes, register map, state and payload types.
// No dependencies; imported by dlmc_step, the top level and the testbench.

package dlmc_pkg;

   typedef enum logic [1:0] {
      DIR_UP   = 2'd0,
      DIR_DOWN = 2'd1,
      DIR_STOP = 2'd2
   } dlmc_dir_type;

   typedef enum logic [2:0] {
      CMD_NONE = 3'd0,
      CMD_SET  = 3'd1,
      CMD_HIGH = 3'd2,
      CMD_LOW  = 3'd3,
      CMD_STOP = 3'd4
   } dlmc_cmd_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_HEIGHT = 2'd1,
      EV_OTHER  = 2'd2
   } dlmc_event_type;

   typedef enum logic [2:0] {
      CSR_HIGH_PRESET  = 3'd0,
      CSR_LOW_PRESET   = 3'd1,
      CSR_UPPER_LIMIT  = 3'd2,
      CSR_LOWER_LIMIT  = 3'd3,
      CSR_DEBOUNCE_MS  = 3'd4,
      CSR_DOUBLE_MS    = 3'd5,
      CSR_GIVEUP_MS    = 3'd6
   } dlmc_csr_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [7:0]  HIGH_PRESET_RST  = 8'd110;
   localparam logic [7:0]  LOW_PRESET_RST   = 8'd80;
   localparam logic [7:0]  UPPER_LIMIT_RST  = 8'd114;
   localparam logic [7:0]  LOWER_LIMIT_RST  = 8'd70;
   localparam logic [15:0] DEBOUNCE_MS_RST  = 16'd50;
   localparam logic [15:0] DOUBLE_MS_RST    = 16'd500;
   localparam logic [15:0] GIVEUP_MS_RST    = 16'd2000;

   typedef struct packed {
      logic [7:0]  high_preset;
      logic [7:0]  low_preset;
      logic [7:0]  upper_limit;
      logic [7:0]  lower_limit;
      logic [15:0] debounce_ms;
      logic [15:0] double_press_ms;
      logic [15:0] giveup_ms;
   } dlmc_cfg_type;

   typedef struct packed {
      logic [7:0]        cur_height;
      logic [7:0]        tgt_height;
      logic              seeking;
      dlmc_dir_type      dir;
      logic [1:0]        drive_lines;   // bit 0 up, bit 1 down
      logic              halt;
      logic [1:0]        pressed;       // bit 0 up, bit 1 down
      logic [1:0][31:0]  change_time;
      logic [1:0][31:0]  press_time;
      logic [31:0]       act_time;
   } dlmc_state_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        button_up;
      logic        button_down;
      logic [1:0]  display_event;
      logic [7:0]  reported_height;
      logic [2:0]  command;
      logic [7:0]  requested_height;
   } dlmc_req_type;

   typedef struct packed {
      logic        drive_up;
      logic        drive_down;
      logic [1:0]  motion;
      logic [7:0]  height_now;
      logic [7:0]  height_goal;
      logic        seek_active;
      logic        halted;
      logic        command_rejected;
   } dlmc_rsp_type;

endpackage

[hw/rtl/dlmc_req_if.sv]
// Request channel of the desk lift controller: valid/ready plus one control pass.
// Standalone; no package dependency.

interface dlmc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic        button_up;
   logic        button_down;
   logic [1:0]  display_event;
   logic [7:0]  reported_height;
   logic [2:0]  command;
   logic [7:0]  requested_height;

   modport source (
      output valid, now_ms, button_up, button_down, display_event,
             reported_height, command, requested_height,
      input  ready
   );

   modport sink (
      input  valid, now_ms, button_up, button_down, display_event,
             reported_height, command, requested_height,
      output ready
   );
endinterface

[hw/rtl/dlmc_rsp_if.sv]
// Response channel of the desk lift controller: valid/ready plus drive and status fields.
// Standalone; no package dependency.

interface dlmc_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_up;
   logic       drive_down;
   logic [1:0] motion;
   logic [7:0] height_now;
   logic [7:0] height_goal;
   logic       seek_active;
   logic       halted;
   logic       command_rejected;

   modport source (
      output valid, drive_up, drive_down, motion, height_now, height_goal,
             seek_active, halted, command_rejected,
      input  ready
   );

   modport sink (
      input  valid, drive_up, drive_down, motion, height_now, height_goal,
             seek_active, halted, command_rejected,
      output ready
   );
endinterface

[hw/rtl/dlmc_step.sv]
// One control pass: next controller state and response from current state and request.
// Depends on dlmc_pkg.

module dlmc_step (
   input  dlmc_pkg::dlmc_cfg_type   cfg,
   input  dlmc_pkg::dlmc_state_type state_cur,
   input  dlmc_pkg::dlmc_req_type   req,
   output dlmc_pkg::dlmc_state_type state_next,
   output dlmc_pkg::dlmc_rsp_type   rsp
);
   import dlmc_pkg::*;

   function automatic logic height_ok(logic [7:0] h, dlmc_dir_type d, dlmc_cfg_type c);
      logic ok;
      ok = (h >= c.lower_limit && h <= c.upper_limit)
        || (d == DIR_UP && h <= c.upper_limit)
        || (d == DIR_DOWN && h >= c.lower_limit);
      return ok;
   endfunction

   function automatic dlmc_state_type halt_motion(dlmc_state_type st);
      dlmc_state_type r;
      r             = st;
      r.drive_lines = 2'b00;
      r.tgt_height  = st.cur_height;
      r.seeking     = 1'b0;
      r.dir         = DIR_STOP;
      return r;
   endfunction

   function automatic dlmc_state_type drive(dlmc_state_type st, dlmc_dir_type d,
                                            dlmc_cfg_type c);
      dlmc_state_type r;
      r = st;
      if (st.cur_height == 8'd0 || height_ok(st.cur_height, d, c)) begin
         r.drive_lines = (d == DIR_UP) ? 2'b01 : 2'b10;
         r.dir         = d;
      end else begin
         r = halt_motion(st);
      end
      return r;
   endfunction

   dlmc_state_type s;
   logic           rejected;
   logic [1:0]     lvl;
   logic [31:0]    idle_ms;
   dlmc_dir_type   seek_dir;

   always_comb begin
      s        = state_cur;
      rejected = 1'b0;
      lvl      = {req.button_down, req.button_up};
      idle_ms  = '0;
      seek_dir = DIR_STOP;

      if (!state_cur.halt) begin
         if (req.display_event == EV_HEIGHT) begin
            if (req.reported_height != s.cur_height) begin
               s.cur_height = req.reported_height;
               s.act_time   = req.now_ms;
            end
         end else if (req.display_event == EV_OTHER) begin
            s.act_time = req.now_ms;
         end

         case (req.command)
            CMD_SET: begin
               if (height_ok(req.requested_height, DIR_STOP, cfg)) begin
                  s.tgt_height = req.requested_height;
                  s.seeking    = 1'b1;
               end else begin
                  rejected = 1'b1;
               end
            end
            CMD_HIGH: begin
               s.seeking    = 1'b1;
               s.tgt_height = cfg.high_preset;
            end
            CMD_LOW: begin
               s.seeking    = 1'b1;
               s.tgt_height = cfg.low_preset;
            end
            CMD_STOP: s = halt_motion(s);
            default: ;
         endcase

         // up button first, then down
         for (int i = 0; i < 2; i++) begin
            if (lvl[i[0]] != s.pressed[i[0]] &&
                (req.now_ms - s.change_time[i[0]]) > {16'd0, cfg.debounce_ms}) begin
               s.pressed[i[0]]     = lvl[i[0]];
               s.change_time[i[0]] = req.now_ms;
               s.act_time          = req.now_ms;
               if (lvl[i[0]]) begin
                  if ((req.now_ms - s.press_time[i[0]]) < {16'd0, cfg.double_press_ms}) begin
                     s.seeking    = 1'b1;
                     s.tgt_height = i[0] ? cfg.low_preset : cfg.high_preset;
                  end else begin
                     s.press_time[i[0]] = req.now_ms;
                     s.seeking          = 1'b0;
                  end
               end
            end
         end

         idle_ms  = req.now_ms - s.act_time;
         seek_dir = (s.cur_height > s.tgt_height) ? DIR_DOWN : DIR_UP;

         if (s.pressed[0] && s.pressed[1]) begin
            if (!s.seeking && idle_ms > {16'd0, cfg.giveup_ms}) begin
               s      = halt_motion(s);
               s.halt = 1'b1;
            end else if (s.cur_height != s.tgt_height) begin
               if (s.seeking) begin
                  s = drive(s, seek_dir, cfg);
               end
            end else begin
               s = halt_motion(s);
            end
         end else if (s.pressed[0]) begin
            s = drive(s, DIR_UP, cfg);
         end else if (s.pressed[1]) begin
            s = drive(s, DIR_DOWN, cfg);
         end else if (!s.seeking) begin
            if (s.dir != DIR_STOP) begin
               s = halt_motion(s);
            end
         end else if (s.cur_height != s.tgt_height) begin
            s = drive(s, seek_dir, cfg);
         end else begin
            s = halt_motion(s);
         end
      end

      state_next           = s;
      rsp.drive_up         = s.drive_lines[0];
      rsp.drive_down       = s.drive_lines[1];
      rsp.motion           = s.dir;
      rsp.height_now       = s.cur_height;
      rsp.height_goal      = s.tgt_height;
      rsp.seek_active      = s.seeking;
      rsp.halted           = s.halt;
      rsp.command_rejected = rejected;
   end

endmodule

[hw/rtl/desk_lift_motion_controller.sv]
// Desk lift motion controller top level: config registers, state and response registers.
// Depends on dlmc_pkg, dlmc_req_if, dlmc_rsp_if and dlmc_step.

// Each request transaction is one control pass (display report, remote command, debounced
// buttons, motor drive) and yields exactly one response transaction. A pass is evaluated in
// the cycle it is accepted and its response is registered; a new request is taken every
// cycle while the response register is empty or being drained, and the single response
// register is the only buffering. Configuration writes take effect from the next edge and
// are meant to happen while the block is idle. A safety halt, once latched, freezes the
// reported state with drives off until reset.

module desk_lift_motion_controller (
   input  logic                              clock,
   input  logic                              reset,
   dlmc_req_if.sink                          req_chan,
   dlmc_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [dlmc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dlmc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dlmc_pkg::*;

   dlmc_cfg_type   cfg_ff;
   dlmc_cfg_type   cfg_in;
   dlmc_state_type state_ff;
   dlmc_state_type state_in;
   dlmc_rsp_type   rsp_ff;
   dlmc_rsp_type   rsp_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   dlmc_req_type   req;
   logic           accept;

   assign req.now_ms           = req_chan.now_ms;
   assign req.button_up        = req_chan.button_up;
   assign req.button_down      = req_chan.button_down;
   assign req.display_event    = req_chan.display_event;
   assign req.reported_height  = req_chan.reported_height;
   assign req.command          = req_chan.command;
   assign req.requested_height = req_chan.requested_height;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   dlmc_step u_step (
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .req        (req),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HIGH_PRESET: cfg_in.high_preset     = csr_wdata[7:0];
            CSR_LOW_PRESET:  cfg_in.low_preset      = csr_wdata[7:0];
            CSR_UPPER_LIMIT: cfg_in.upper_limit     = csr_wdata[7:0];
            CSR_LOWER_LIMIT: cfg_in.lower_limit     = csr_wdata[7:0];
            CSR_DEBOUNCE_MS: cfg_in.debounce_ms     = csr_wdata;
            CSR_DOUBLE_MS:   cfg_in.double_press_ms = csr_wdata;
            CSR_GIVEUP_MS:   cfg_in.giveup_ms       = csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_preset     <= HIGH_PRESET_RST;
         cfg_ff.low_preset      <= LOW_PRESET_RST;
         cfg_ff.upper_limit     <= UPPER_LIMIT_RST;
         cfg_ff.lower_limit     <= LOWER_LIMIT_RST;
         cfg_ff.debounce_ms     <= DEBOUNCE_MS_RST;
         cfg_ff.double_press_ms <= DOUBLE_MS_RST;
         cfg_ff.giveup_ms       <= GIVEUP_MS_RST;
         state_ff               <= '{dir: DIR_STOP, default: '0};
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.drive_up         = rsp_ff.drive_up;
   assign rsp_chan.drive_down       = rsp_ff.drive_down;
   assign rsp_chan.motion           = rsp_ff.motion;
   assign rsp_chan.height_now       = rsp_ff.height_now;
   assign rsp_chan.height_goal      = rsp_ff.height_goal;
   assign rsp_chan.seek_active      = rsp_ff.seek_active;
   assign rsp_chan.halted           = rsp_ff.halted;
   assign rsp_chan.command_rejected = rsp_ff.command_rejected;

endmodule

[test/tb_desk_lift_motion_controller.sv]
`timescale 1ns / 1ps
// Testbench for desk_lift_motion_controller: directed and random control passes with a
// scoreboard class that predicts each response transaction and checks the RTL against it.
// Depends on dlmc_pkg, dlmc_req_if, dlmc_rsp_if and the desk_lift_motion_controller RTL.

module tb_desk_lift_motion_controller;
   import dlmc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SINK_HOLD = 300;
   localparam logic [1:0] EV_UNUSED = 2'd3;
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [7:0]       cur_h;
      logic [7:0]       goal_h;
      logic             seek;
      logic             halt;
      dlmc_dir_type     dir;
      logic [1:0]       lines;
      logic [1:0]       held;
      logic [1:0][31:0] change_t;
      logic [1:0][31:0] press_t;
      logic [31:0]      act_t;
   } lift_state_type;

   class lift_status_tracker;
      dlmc_cfg_type cfg;
      lift_state_type st;
      dlmc_rsp_type status_due[$];
      int errors;

      function new();
         cfg = '{high_preset: HIGH_PRESET_RST, low_preset: LOW_PRESET_RST,
                 upper_limit: UPPER_LIMIT_RST, lower_limit: LOWER_LIMIT_RST,
                 debounce_ms: DEBOUNCE_MS_RST, double_press_ms: DOUBLE_MS_RST,
                 giveup_ms: GIVEUP_MS_RST};
         st = '0;
         st.dir = DIR_STOP;
         errors = 0;
      endfunction

      function bit height_ok(logic [7:0] h, dlmc_dir_type d);
         return (h >= cfg.lower_limit && h <= cfg.upper_limit)
             || (d == DIR_UP && h <= cfg.upper_limit)
             || (d == DIR_DOWN && h >= cfg.lower_limit);
      endfunction

      function void halt_lift(inout lift_state_type s);
         s.lines = 2'b00;
         s.goal_h = s.cur_h;
         s.seek = 1'b0;
         s.dir = DIR_STOP;
      endfunction

      function void run_motor(inout lift_state_type s, input dlmc_dir_type d);
         if (s.cur_h == 8'd0 || height_ok(s.cur_h, d)) begin
            s.lines = (d == DIR_UP) ? 2'b01 : 2'b10;
            s.dir = d;
         end else begin
            halt_lift(s);
         end
      endfunction

      function lift_state_type next_lift_state(lift_state_type s, dlmc_req_type r,
                                               output dlmc_rsp_type o);
         logic [1:0] lvl;
         logic rejected;
         logic [31:0] since;
         lvl = {r.button_down, r.button_up};
         rejected = 1'b0;
         if (!s.halt) begin
            if (r.display_event == EV_HEIGHT) begin
               if (r.reported_height != s.cur_h) begin
                  s.cur_h = r.reported_height;
                  s.act_t = r.now_ms;
               end
            end else if (r.display_event == EV_OTHER) begin
               s.act_t = r.now_ms;
            end
            case (r.command)
               CMD_SET: begin
                  if (height_ok(r.requested_height, DIR_STOP)) begin
                     s.goal_h = r.requested_height;
                     s.seek = 1'b1;
                  end else begin
                     rejected = 1'b1;
                  end
               end
               CMD_HIGH: begin
                  s.seek = 1'b1;
                  s.goal_h = cfg.high_preset;
               end
               CMD_LOW: begin
                  s.seek = 1'b1;
                  s.goal_h = cfg.low_preset;
               end
               CMD_STOP: halt_lift(s);
               default: ;
            endcase
            for (int b = 0; b < 2; b++) begin
               since = r.now_ms - s.change_t[b];
               if (lvl[b] != s.held[b] && since > {16'd0, cfg.debounce_ms}) begin
                  s.held[b] = lvl[b];
                  s.change_t[b] = r.now_ms;
                  s.act_t = r.now_ms;
                  if (lvl[b]) begin
                     since = r.now_ms - s.press_t[b];
                     if (since < {16'd0, cfg.double_press_ms}) begin
                        s.seek = 1'b1;
                        s.goal_h = (b == 0) ? cfg.high_preset : cfg.low_preset;
                     end else begin
                        s.press_t[b] = r.now_ms;
                        s.seek = 1'b0;
                     end
                  end
               end
            end
            since = r.now_ms - s.act_t;
            if (s.held == 2'b11) begin
               if (!s.seek && since > {16'd0, cfg.giveup_ms}) begin
                  halt_lift(s);
                  s.halt = 1'b1;
               end else if (s.cur_h != s.goal_h) begin
                  if (s.seek) run_motor(s, (s.cur_h > s.goal_h) ? DIR_DOWN : DIR_UP);
               end else begin
                  halt_lift(s);
               end
            end else if (s.held[0]) begin
               run_motor(s, DIR_UP);
            end else if (s.held[1]) begin
               run_motor(s, DIR_DOWN);
            end else if (!s.seek) begin
               if (s.dir != DIR_STOP) halt_lift(s);
            end else if (s.cur_h != s.goal_h) begin
               run_motor(s, (s.cur_h > s.goal_h) ? DIR_DOWN : DIR_UP);
            end else begin
               halt_lift(s);
            end
         end
         o.drive_up = s.lines[0];
         o.drive_down = s.lines[1];
         o.motion = s.dir;
         o.height_now = s.cur_h;
         o.height_goal = s.goal_h;
         o.seek_active = s.seek;
         o.halted = s.halt;
         o.command_rejected = rejected;
         return s;
      endfunction

      function bit halts_on(dlmc_req_type r);
         lift_state_type s;
         dlmc_rsp_type o;
         s = next_lift_state(st, r, o);
         return s.halt && !st.halt;
      endfunction

      function void note_pass(dlmc_req_type r);
         dlmc_rsp_type o;
         st = next_lift_state(st, r, o);
         status_due.push_back(o);
      endfunction

      function string show(dlmc_rsp_type r);
         return {$sformatf("up=%0d down=%0d motion=%0d height=%0d ",
                           r.drive_up, r.drive_down, r.motion, r.height_now),
                 $sformatf("goal=%0d seek=%0d halt=%0d rej=%0d",
                           r.height_goal, r.seek_active, r.halted, r.command_rejected)};
      endfunction

      function void check_status(dlmc_rsp_type got);
         dlmc_rsp_type want;
         if (status_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response transaction: %s", show(got));
            return;
         end
         want = status_due.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) begin
               $display("response mismatch at %0t", $realtime);
               $display("  expected %s", show(want));
               $display("  actual   %s", show(got));
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dlmc_req_if req_chan();
   dlmc_rsp_if rsp_chan();

   desk_lift_motion_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lift_status_tracker sb = new();
   logic [31:0] t_ms;
   logic [1:0] lvl;
   bit halt_ok;
   bit steady;
   bit hold_sink;
   int quiet_cycles;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_sink) begin
            rsp_chan.ready <= 1'b0;
            repeat (SINK_HOLD) @(posedge clock);
            hold_sink = 1'b0;
         end
         rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 11);
      end
   end

   always @(posedge clock) begin
      dlmc_rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{drive_up: rsp_chan.drive_up, drive_down: rsp_chan.drive_down,
                 motion: rsp_chan.motion, height_now: rsp_chan.height_now,
                 height_goal: rsp_chan.height_goal, seek_active: rsp_chan.seek_active,
                 halted: rsp_chan.halted, command_rejected: rsp_chan.command_rejected};
         sb.check_status(got);
      end
   end

   // no transaction on either channel for too long: give up
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic offer(input dlmc_req_type r);
      if (!halt_ok && sb.halts_on(r)) r.display_event = EV_OTHER;
      if (!steady && $urandom_range(0, 99) < 11) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.now_ms <= r.now_ms;
      req_chan.button_up <= r.button_up;
      req_chan.button_down <= r.button_down;
      req_chan.display_event <= r.display_event;
      req_chan.reported_height <= r.reported_height;
      req_chan.command <= r.command;
      req_chan.requested_height <= r.requested_height;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_pass(r);
   endtask

   task automatic pass_item(input logic [31:0] now, input logic up, input logic dn,
                            input logic [1:0] ev, input logic [7:0] rep,
                            input logic [2:0] cmd, input logic [7:0] reqh);
      offer('{now_ms: now, button_up: up, button_down: dn, display_event: ev,
              reported_height: rep, command: cmd, requested_height: reqh});
      t_ms = now;
      lvl = {dn, up};
   endtask

   function automatic dlmc_req_type next_pass();
      dlmc_req_type r;
      int b;
      int roll;
      r = '0;
      b = $urandom_range(0, 1);
      if ($urandom_range(0, 4) == 0) lvl[0] = !lvl[0];
      if ($urandom_range(0, 4) == 0) lvl[1] = !lvl[1];
      roll = $urandom_range(0, 19);
      if (roll < 9) begin
         t_ms = t_ms + $urandom_range(1, 40);
      end else if (roll < 14) begin
         t_ms = t_ms + $urandom_range(41, 600);
      end else if (roll < 16) begin
         t_ms = t_ms + $urandom_range(601, 4000);
      end else if (roll == 16) begin
         t_ms = t_ms + $urandom_range(4000, 70000);
      end else if (roll == 17) begin
         // land right on the debounce boundary
         t_ms = sb.st.change_t[b] + {16'd0, sb.cfg.debounce_ms} + $urandom_range(0, 1);
         lvl[b] = !sb.st.held[b];
      end else if (roll == 18) begin
         // second press right at the edge of the double-press window
         t_ms = sb.st.press_t[b] + {16'd0, sb.cfg.double_press_ms} - $urandom_range(0, 1);
         lvl[b] = 1'b1;
      end
      r.now_ms = t_ms;
      r.button_up = lvl[0];
      r.button_down = lvl[1];

      roll = $urandom_range(0, 19);
      if (roll < 10) begin
         r.display_event = EV_HEIGHT;
         if ($urandom_range(0, 9) < 7) begin
            // desk follows the motor
            if (sb.st.cur_h == 8'd0) r.reported_height = 8'($urandom_range(60, 125));
            else if (sb.st.lines == 2'b01)
               r.reported_height = sb.st.cur_h + 8'($urandom_range(1, 2));
            else if (sb.st.lines == 2'b10)
               r.reported_height = sb.st.cur_h - 8'($urandom_range(1, 2));
            else r.reported_height = sb.st.cur_h;
         end else begin
            r.reported_height = 8'($urandom_range(0, 255));
         end
      end else begin
         r.reported_height = 8'($urandom_range(0, 255));
         if (roll < 14) r.display_event = EV_OTHER;
         else if (roll < 19) r.display_event = EV_NONE;
         else r.display_event = EV_UNUSED;
      end

      r.requested_height = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 29);
      if (roll < 22) begin
         r.command = CMD_NONE;
      end else if (roll < 24) begin
         r.command = CMD_SET;
         if (sb.cfg.lower_limit <= sb.cfg.upper_limit)
            r.requested_height = 8'($urandom_range(sb.cfg.lower_limit, sb.cfg.upper_limit));
      end else if (roll == 24) begin
         r.command = CMD_SET;
      end else if (roll == 25) begin
         r.command = CMD_HIGH;
      end else if (roll == 26) begin
         r.command = CMD_LOW;
      end else if (roll == 27) begin
         r.command = CMD_STOP;
      end else begin
         r.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end
      return r;
   endfunction

   task automatic random_passes(input int n);
      repeat (n) offer(next_pass());
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (sb.status_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input dlmc_csr_type idx, input logic [15:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_HIGH_PRESET: sb.cfg.high_preset = v[7:0];
         CSR_LOW_PRESET:  sb.cfg.low_preset = v[7:0];
         CSR_UPPER_LIMIT: sb.cfg.upper_limit = v[7:0];
         CSR_LOWER_LIMIT: sb.cfg.lower_limit = v[7:0];
         CSR_DEBOUNCE_MS: sb.cfg.debounce_ms = v;
         CSR_DOUBLE_MS:   sb.cfg.double_press_ms = v;
         CSR_GIVEUP_MS:   sb.cfg.giveup_ms = v;
         default: ;
      endcase
   endtask

   function automatic logic [15:0] byte_reg(input int v);
      // junk in the upper byte should be dropped by 8 bit registers
      return {8'($urandom_range(0, 255)), 8'(v)};
   endfunction

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.now_ms <= '0;
      req_chan.button_up <= 1'b0;
      req_chan.button_down <= 1'b0;
      req_chan.display_event <= EV_NONE;
      req_chan.reported_height <= '0;
      req_chan.command <= CMD_NONE;
      req_chan.requested_height <= '0;
      halt_ok = 1'b0;
      steady = 1'b0;
      hold_sink = 1'b0;
      t_ms = '0;
      lvl = 2'b00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      pass_item(32'd0, 0, 0, EV_NONE, 8'd0, CMD_NONE, 8'd0);
      pass_item(32'd20, 1, 0, EV_NONE, 8'd0, CMD_NONE, 8'd0);       // inside debounce of t=0
      pass_item(32'd30, 0, 0, EV_HEIGHT, 8'd90, CMD_NONE, 8'd0);
      pass_item(32'd31, 0, 0, EV_HEIGHT, 8'd90, CMD_NONE, 8'd0);     // same height again
      pass_item(32'd40, 0, 0, EV_UNUSED, 8'd200, CMD_NONE, 8'd0);
      pass_item(32'd41, 0, 0, EV_OTHER, 8'd0, CMD_SET, 8'd100);
      pass_item(32'd42, 0, 0, EV_HEIGHT, 8'd100, CMD_NONE, 8'd0);
      pass_item(32'd43, 0, 0, EV_NONE, 8'd0, CMD_SET, 8'd200);
      pass_item(32'd44, 0, 0, EV_NONE, 8'd0, CMD_SET, 8'd0);
      pass_item(32'd45, 0, 0, EV_NONE, 8'd0, CMD_SET, 8'd70);
      pass_item(32'd46, 0, 0, EV_NONE, 8'd0, CMD_STOP, 8'd0);
      pass_item(32'd47, 0, 0, EV_NONE, 8'd0, CMD_HIGH, 8'd0);
      pass_item(32'd48, 0, 0, EV_NONE, 8'd0, CMD_LOW, 8'd0);
      pass_item(32'd49, 0, 0, EV_NONE, 8'd0, CMD_SPARE_LO, 8'd0);
      pass_item(32'd50, 0, 0, EV_NONE, 8'd0, CMD_SPARE_HI, 8'd0);
      pass_item(32'd100, 1, 0, EV_NONE, 8'd0, CMD_NONE, 8'd0);
      pass_item(32'd160, 0, 0, EV_NONE, 8'd0, CMD_NONE, 8'd0);
      pass_item(32'd180, 1, 0, EV_NONE, 8'd0, CMD_NONE, 8'd0);
      pass_item(32'd700, 1, 0, EV_NONE, 8'd0, CMD_NONE, 8'd0);       // single press
      pass_item(32'd760, 0, 0, EV_NONE, 8'd0, CMD_NONE, 8'd0);
      pass_item(32'd820, 1, 0, EV_NONE, 8'd0, CMD_NONE, 8'd0);       // double press
      pass_item(32'd900, 0, 1, EV_HEIGHT, 8'd255, CMD_NONE, 8'd0);
      pass_item(32'd1000, 1, 0, EV_HEIGHT, 8'd255, CMD_NONE, 8'd0);
      pass_item(32'd1100, 1, 1, EV_HEIGHT, 8'd0, CMD_NONE, 8'd0);
      pass_item(32'hFFFF_FFFF, 1, 1, EV_OTHER, 8'hFF, CMD_SPARE_HI, 8'hFF);
      pass_item(32'd0, 0, 0, EV_HEIGHT, 8'd75, CMD_NONE, 8'd0);      // time wraps
      random_passes(150);

      settle();
      write_reg(CSR_HIGH_PRESET, byte_reg(255));
      write_reg(CSR_LOW_PRESET, byte_reg(0));
      write_reg(CSR_UPPER_LIMIT, byte_reg(255));
      write_reg(CSR_LOWER_LIMIT, byte_reg(0));
      write_reg(CSR_DEBOUNCE_MS, 16'd0);
      write_reg(CSR_DOUBLE_MS, 16'hFFFF);
      write_reg(CSR_GIVEUP_MS, 16'hFFFF);
      random_passes(120);

      settle();
      write_reg(CSR_HIGH_PRESET, byte_reg(130));
      write_reg(CSR_LOW_PRESET, byte_reg(90));
      write_reg(CSR_UPPER_LIMIT, byte_reg(120));
      write_reg(CSR_LOWER_LIMIT, byte_reg(100));
      write_reg(CSR_DEBOUNCE_MS, 16'hFFFF);
      write_reg(CSR_DOUBLE_MS, 16'd0);
      write_reg(CSR_GIVEUP_MS, 16'd0);
      t_ms = 32'hFFFF_F000;
      random_passes(120);

      settle();
      write_reg(CSR_HIGH_PRESET, byte_reg($urandom_range(0, 255)));
      write_reg(CSR_LOW_PRESET, byte_reg($urandom_range(0, 255)));
      write_reg(CSR_UPPER_LIMIT, byte_reg($urandom_range(0, 255)));
      write_reg(CSR_LOWER_LIMIT, byte_reg($urandom_range(0, 255)));
      write_reg(CSR_DEBOUNCE_MS, 16'($urandom_range(0, 200)));
      write_reg(CSR_DOUBLE_MS, 16'($urandom_range(0, 1000)));
      write_reg(CSR_GIVEUP_MS, 16'($urandom_range(0, 5000)));
      steady = 1'b1;
      random_passes(100);
      steady = 1'b0;
      hold_sink = 1'b1;   // sink backs off, request side should stall
      random_passes(120);

      settle();
      write_reg(CSR_HIGH_PRESET, {8'd0, HIGH_PRESET_RST});
      write_reg(CSR_LOW_PRESET, {8'd0, LOW_PRESET_RST});
      write_reg(CSR_UPPER_LIMIT, {8'd0, UPPER_LIMIT_RST});
      write_reg(CSR_LOWER_LIMIT, {8'd0, LOWER_LIMIT_RST});
      write_reg(CSR_DEBOUNCE_MS, DEBOUNCE_MS_RST);
      write_reg(CSR_DOUBLE_MS, DOUBLE_MS_RST);
      write_reg(CSR_GIVEUP_MS, GIVEUP_MS_RST);
      random_passes(80);

      // latch the safety halt: both held, no seek, long silence
      settle();
      write_reg(CSR_DEBOUNCE_MS, 16'd0);
      write_reg(CSR_DOUBLE_MS, 16'd0);
      write_reg(CSR_GIVEUP_MS, 16'd10);
      halt_ok = 1'b1;
      pass_item(t_ms + 32'd100, 1, 1, EV_NONE, 8'd0, CMD_NONE, 8'd0);
      pass_item(t_ms + 32'd5000, 1, 1, EV_NONE, 8'd0, CMD_STOP, 8'd0);
      random_passes(25);

      settle();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.status_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/dlmc_pkg.sv
hw/rtl/dlmc_req_if.sv
hw/rtl/dlmc_rsp_if.sv
hw/rtl/dlmc_step.sv
hw/rtl/desk_lift_motion_controller.sv
test/tb_desk_lift_motion_controller.sv
